@@ sv/linear_probe_hash_map_unit_defines.svh @@
// Assertion macros for the hash map RTL.
`ifndef LINEAR_PROBE_HASH_MAP_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPHM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/lphm_pkg.sv @@
// Shared types and codes of the linear probing hash map.
package lphm_pkg;

	// Field widths of one beat.
	localparam int unsigned OP_W     = 2;
	localparam int unsigned KEY_W    = 31;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STATUS_W = 2;

	// Operation codes; the fourth code is unused and answers a miss.
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// One table slot as stored in the memory.
	typedef struct packed {
		logic             ever;
		logic             live;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

@@ sv/lphm_home.sv @@
// Home slot unit: key modulo the table size.
module lphm_home #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lphm_pkg::KEY_W-1:0]        key,
	output logic                              done,
	output logic [$clog2(SLOTS)-1:0]          home
);

	localparam int unsigned     IDXW    = $clog2(SLOTS);
	localparam bit              IS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
	localparam int unsigned     KW      = lphm_pkg::KEY_W;
	// Reciprocal of the size, rounded up, scaled so the quotient is exact for every key.
	localparam int unsigned     SH      = KW + IDXW;
	localparam longint unsigned RECIP   = ((64'd1 << SH) + SLOTS - 1) / SLOTS;
	localparam int unsigned     RECIP_W = KW + 1;
	localparam int unsigned     PROD_W  = KW + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

	logic                              busy_q;
	logic                              done_q;
	logic [KW-1:0]                     key_s1;
	logic [PROD_W-1:0]                 prod_s1;
	logic [IDXW-1:0]                   rem_q;
	logic [PROD_W-SH-1:0]              quot;
	logic [KW-1:0]                     back;
	logic [KW-1:0]                     diff;

	// Quotient from the registered product, then the remainder by multiply-back.
	always_comb begin
		quot = prod_s1[PROD_W-1:SH];
		back = KW'(quot) * KW'(SLOTS);
		diff = key_s1 - back;
	end

	// A power-of-two size is a mask; any other size passes through busy_q before done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			busy_q <= 1'b0;
			if (start) begin
				if (IS_POW2) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				done_q <= 1'b1;
			end
		end
	end

	// Remainder datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			key_s1  <= key;
			prod_s1 <= PROD_W'(key) * PROD_W'(RECIP_C);
		end
		if (start && IS_POW2) begin
			rem_q <= key[IDXW-1:0];
		end else if (busy_q) begin
			rem_q <= diff[IDXW-1:0];
		end
	end

	assign done = done_q;
	assign home = rem_q;

endmodule

@@ sv/lphm_mem.sv @@
// Slot memory: one write port and one registered read port.
module lphm_mem #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [$clog2(SLOTS)-1:0]       wr_addr,
	input  lphm_pkg::entry_t               wr_data,
	input  logic                           rd_en,
	input  logic [$clog2(SLOTS)-1:0]       rd_addr,
	output lphm_pkg::entry_t               rd_data
);

	lphm_pkg::entry_t mem_q [SLOTS];
	lphm_pkg::entry_t rd_data_q;

	// Write and read in the same clocked block; a read sees the old word.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/linear_probe_hash_map_unit.sv @@
// Linear probing hash map: one beat in is an insert, search or remove, and one result beat
// comes out for it. After reset the block clears every slot of its memory in turn and
// accepts no beat meanwhile. An operation then goes through its accept, the home slot
// computation (a mask when SLOTS is a power of two, otherwise a reciprocal multiplication
// and then a multiply-back and subtract), the probe of 1 to SLOTS slots one after another
// through the single memory read port, and the hand-over of the result to the output
// register. The unused opcode skips the probe and answers a miss. The output register lets
// a new beat be taken while the previous result waits.
`include "linear_probe_hash_map_unit_defines.svh"

module linear_probe_hash_map_unit #(
	parameter int unsigned SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [30:0], value [62:31], zero [63]
	input  logic [1:0]  s_tuser,   // opcode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // found_value [31:0]
	output logic [1:0]  m_tuser    // status [1:0]
);

	localparam int unsigned IDXW = $clog2(SLOTS);
	localparam logic [IDXW-1:0] LAST = IDXW'(SLOTS - 1);

	// Controller states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]                         state_q;
	logic [2:0]                         state_d;
	logic [IDXW-1:0]                    clr_q;
	logic [lphm_pkg::OP_W-1:0]          op_q;
	logic [lphm_pkg::KEY_W-1:0]         key_q;
	logic [lphm_pkg::VAL_W-1:0]         val_q;
	logic [IDXW-1:0]                    iss_q;
	logic [IDXW-1:0]                    cnt_q;
	logic                               ff_vld_q;
	logic [IDXW-1:0]                    ff_q;
	logic [lphm_pkg::STATUS_W-1:0]      res_status_q;
	logic signed [lphm_pkg::VAL_W-1:0]  res_fv_q;
	logic                               out_vld_q;
	logic [lphm_pkg::STATUS_W-1:0]      out_status_q;
	logic signed [lphm_pkg::VAL_W-1:0]  out_fv_q;

	logic                               in_beat;
	logic                               op_known;
	logic                               hash_done;
	logic [IDXW-1:0]                    home;
	logic                               wr_en;
	logic [IDXW-1:0]                    wr_addr;
	lphm_pkg::entry_t                   wr_data;
	logic                               rd_en;
	logic [IDXW-1:0]                    rd_addr;
	lphm_pkg::entry_t                   ent;
	logic [IDXW-1:0]                    next_slot;
	logic                               hit;
	logic                               stop;
	logic                               ins_ok;
	logic [IDXW-1:0]                    ins_slot;
	logic [lphm_pkg::STATUS_W-1:0]      status_d;
	logic signed [lphm_pkg::VAL_W-1:0]  fv_d;
	logic                               out_load;

	assign s_tready = (state_q == S_IDLE);
	assign in_beat  = s_tvalid && s_tready;
	assign out_load = (state_q == S_RESP) && (!out_vld_q || m_tready);

	// Only the three defined operations need a home slot and a probe.
	assign op_known = (s_tuser == lphm_pkg::OP_INSERT) || (s_tuser == lphm_pkg::OP_SEARCH) ||
		(s_tuser == lphm_pkg::OP_REMOVE);

	lphm_home #(
		.SLOTS(SLOTS)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_beat && op_known),
		.key   (s_tdata[lphm_pkg::KEY_W-1:0]),
		.done  (hash_done),
		.home  (home)
	);

	lphm_mem #(
		.SLOTS(SLOTS)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ent)
	);

	// Probe evaluation: the read data belongs to the slot issued last cycle.
	always_comb begin
		next_slot = (iss_q == LAST) ? '0 : iss_q + 1'b1;
		hit       = ent.live && (ent.key == key_q);
		stop      = hit || !ent.ever || (cnt_q == LAST);
		ins_ok    = ff_vld_q || !ent.live;
		ins_slot  = ff_vld_q ? ff_q : iss_q;
	end

	// Memory port control and the result of a finished probe.
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = clr_q;
		wr_data  = '0;
		rd_en    = 1'b0;
		rd_addr  = home;
		status_d = lphm_pkg::STATUS_MISS;
		fv_d     = '0;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_HASH: begin
				rd_en = hash_done;
			end
			S_PROBE: begin
				rd_en   = !stop;
				rd_addr = next_slot;
				case (op_q)
					lphm_pkg::OP_INSERT: begin
						wr_data = '{ever: 1'b1, live: 1'b1, key: key_q, value: val_q};
						if (hit) begin
							wr_en    = stop;
							wr_addr  = iss_q;
							status_d = lphm_pkg::STATUS_OK;
						end else if (ins_ok) begin
							wr_en    = stop;
							wr_addr  = ins_slot;
							status_d = lphm_pkg::STATUS_OK;
						end else begin
							status_d = lphm_pkg::STATUS_FULL;
						end
					end
					lphm_pkg::OP_SEARCH: begin
						if (hit) begin
							status_d = lphm_pkg::STATUS_OK;
							fv_d     = ent.value;
						end
					end
					lphm_pkg::OP_REMOVE: begin
						// Leave a tombstone: still ever used, no longer live.
						wr_data = '{ever: 1'b1, live: 1'b0, key: ent.key, value: ent.value};
						wr_addr = iss_q;
						if (hit) begin
							wr_en    = stop;
							status_d = lphm_pkg::STATUS_OK;
						end
					end
					default: begin
						status_d = lphm_pkg::STATUS_MISS;
					end
				endcase
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_beat) begin
					if (op_known) begin
						state_d = S_HASH;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_HASH: begin
				if (hash_done) begin
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (stop) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			ff_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_HASH) begin
				ff_vld_q <= 1'b0;
			end else if (state_q == S_PROBE && !ent.live) begin
				ff_vld_q <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Operation, probe and result payload.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q         <= s_tuser;
			key_q        <= s_tdata[lphm_pkg::KEY_W-1:0];
			val_q        <= s_tdata[lphm_pkg::KEY_W+lphm_pkg::VAL_W-1:lphm_pkg::KEY_W];
			res_status_q <= lphm_pkg::STATUS_MISS;
			res_fv_q     <= '0;
		end
		if (state_q == S_HASH) begin
			iss_q <= home;
			cnt_q <= '0;
		end else if (state_q == S_PROBE) begin
			iss_q <= next_slot;
			cnt_q <= cnt_q + 1'b1;
			if (!ff_vld_q && !ent.live) begin
				ff_q <= iss_q;
			end
			if (stop) begin
				res_status_q <= status_d;
				res_fv_q     <= fv_d;
			end
		end
		if (out_load) begin
			out_status_q <= res_status_q;
			out_fv_q     <= res_fv_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_fv_q;
	assign m_tuser  = out_status_q;

	// Checks on the controller.
	`LPHM_ASSERT_NOW(a_wr_phase, clk, arst_n, wr_en, state_q == S_CLEAR || state_q == S_PROBE, "memory written outside clear or probe")
	`LPHM_ASSERT_NOW(a_hash_phase, clk, arst_n, hash_done, state_q == S_HASH, "home slot ready outside hash phase")
	`LPHM_ASSERT_NOW(a_full_insert, clk, arst_n, out_load && res_status_q == lphm_pkg::STATUS_FULL, op_q == lphm_pkg::OP_INSERT, "table full reported for a non-insert")
	`LPHM_ASSERT_NOW(a_value_ok, clk, arst_n, m_tvalid && m_tdata != '0, m_tuser == lphm_pkg::STATUS_OK, "value returned without a hit")
	`LPHM_ASSERT_NEXT(a_accept_next, clk, arst_n, in_beat, state_q == S_HASH || state_q == S_RESP, "accepted beat not taken up")

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the linear probing hash map unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = 16;
	// The fourth opcode has no name in the package; the block answers it with a miss.
	localparam logic [lphm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [lphm_pkg::KEY_W-1:0] KEY_MAX = {lphm_pkg::KEY_W{1'b1}};
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [lphm_pkg::STATUS_W-1:0] status;
		logic [lphm_pkg::VAL_W-1:0]    found_value;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	// Shadow copy of the table, updated as each beat is accepted.
	logic [lphm_pkg::KEY_W-1:0] table_key [SLOTS];
	logic [lphm_pkg::VAL_W-1:0] table_value [SLOTS];
	bit                         table_live [SLOTS];
	bit                         table_ever [SLOTS];

	result_t pending_results [$];
	logic [lphm_pkg::KEY_W-1:0] key_pool [$];

	int  errors;
	int  ops_sent;
	int  directed_ops;
	int  results_checked;
	int  hits_seen;
	int  full_seen;
	int  quiet_cycles;
	int  ready_hold;
	bit  idle_on;

	linear_probe_hash_map_unit #(
		.SLOTS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Walk the probe chain of a key; stops at a never-used slot or a live match.
	function automatic bit locate_key(input logic [lphm_pkg::KEY_W-1:0] key, output int slot);
		int s;
		int n;
		bit hit;
		bit stop;
		s = key % SLOTS;
		hit = 1'b0;
		stop = 1'b0;
		slot = 0;
		for (n = 0; n < SLOTS && !stop; n++) begin
			if (!table_ever[s]) begin
				stop = 1'b1;
			end else if (table_live[s] && table_key[s] == key) begin
				hit = 1'b1;
				stop = 1'b1;
				slot = s;
			end else begin
				s = (s + 1) % SLOTS;
			end
		end
		return hit;
	endfunction

	// Expected result of one operation; updates the shadow table.
	function automatic result_t apply_op(input logic [lphm_pkg::OP_W-1:0] op,
			input logic [lphm_pkg::KEY_W-1:0] key, input logic [lphm_pkg::VAL_W-1:0] val);
		result_t res;
		int slot;
		int s;
		int n;
		int free_slot;
		bit hit;
		res.status = lphm_pkg::STATUS_MISS;
		res.found_value = '0;
		hit = locate_key(key, slot);
		case (op)
			lphm_pkg::OP_INSERT: begin
				if (hit) begin
					table_value[slot] = val;
					res.status = lphm_pkg::STATUS_OK;
				end else begin
					// First slot on the chain that is not live, tombstone or never used.
					free_slot = -1;
					s = key % SLOTS;
					for (n = 0; n < SLOTS && free_slot < 0; n++) begin
						if (!table_live[s])
							free_slot = s;
						s = (s + 1) % SLOTS;
					end
					if (free_slot >= 0) begin
						table_key[free_slot] = key;
						table_value[free_slot] = val;
						table_live[free_slot] = 1'b1;
						table_ever[free_slot] = 1'b1;
						res.status = lphm_pkg::STATUS_OK;
					end else begin
						res.status = lphm_pkg::STATUS_FULL;
					end
				end
			end
			lphm_pkg::OP_SEARCH: begin
				if (hit) begin
					res.status = lphm_pkg::STATUS_OK;
					res.found_value = table_value[slot];
				end
			end
			lphm_pkg::OP_REMOVE: begin
				if (hit) begin
					table_live[slot] = 1'b0;
					res.status = lphm_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Send one operation beat, record its expected result, then idle a random gap if idling is on.
	task automatic send_op(input logic [lphm_pkg::OP_W-1:0] op,
			input logic [lphm_pkg::KEY_W-1:0] key, input logic [lphm_pkg::VAL_W-1:0] val);
		result_t res;
		int idle;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {1'b0, val, key};
		do
			@(posedge clk);
		while (!s_tready);
		res = apply_op(op, key, val);
		pending_results.push_back(res);
		ops_sent++;
		if (op == lphm_pkg::OP_SEARCH && res.status == lphm_pkg::STATUS_OK)
			hits_seen++;
		if (res.status == lphm_pkg::STATUS_FULL)
			full_seen++;
		idle = idle_on ? gap_len() : 0;
		if (idle > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() > 0)
			@(posedge clk);
	endtask

	// Extremes of the fields, collisions, overwrite, tombstones, unused opcode.
	task automatic test_basic_ops();
		send_op(lphm_pkg::OP_SEARCH, 31'd0, 32'h0000_0000);
		send_op(lphm_pkg::OP_INSERT, 31'd0, 32'h7FFF_FFFF);
		send_op(lphm_pkg::OP_INSERT, KEY_MAX, 32'h8000_0000);
		send_op(lphm_pkg::OP_INSERT, 31'd16, 32'hFFFF_FFFF);
		send_op(lphm_pkg::OP_SEARCH, 31'd16, 32'h0);
		send_op(lphm_pkg::OP_INSERT, 31'd0, 32'h0000_0000);
		send_op(lphm_pkg::OP_REMOVE, 31'd0, 32'h0);
		// Key 16 sits behind the new tombstone; insert must overwrite, not duplicate.
		send_op(lphm_pkg::OP_INSERT, 31'd16, 32'h1234_5678);
		send_op(lphm_pkg::OP_REMOVE, 31'd16, 32'h0);
		send_op(lphm_pkg::OP_SEARCH, 31'd16, 32'h0);
		send_op(OP_UNUSED, KEY_MAX, 32'hA5A5_5A5A);
		send_op(lphm_pkg::OP_SEARCH, KEY_MAX, 32'h0);
		send_op(lphm_pkg::OP_REMOVE, 31'd2, 32'h0);
	endtask

	// Fill every slot from one home slot, then hit the full and full-circle cases.
	task automatic test_table_full();
		int i;
		int guard;
		guard = 0;
		for (i = 0; guard < SLOTS; i++) begin
			send_op(lphm_pkg::OP_INSERT, 31'(5 + 16 * i), $urandom);
			guard = 0;
			foreach (table_live[s])
				guard += table_live[s];
		end
		send_op(lphm_pkg::OP_INSERT, 31'h7FFF_FFF5, 32'hDEAD_BEEF);
		send_op(lphm_pkg::OP_SEARCH, 31'h0000_0125, 32'h0);
		send_op(lphm_pkg::OP_REMOVE, 31'(5 + 16 * 3), 32'h0);
		stop_sending();
		wait_drained();
	endtask

	// Key pool: keys live in the table plus fresh keys clustered on a few home slots.
	task automatic build_pool();
		int n;
		int base;
		logic [lphm_pkg::KEY_W-1:0] k;
		key_pool.delete();
		foreach (table_live[s])
			if (table_live[s])
				key_pool.push_back(table_key[s]);
		base = $urandom_range(0, SLOTS - 1);
		repeat ($urandom_range(6, 14)) begin
			k = lphm_pkg::KEY_W'($urandom);
			n = (base + $urandom_range(0, 5)) % SLOTS;
			k[3:0] = n[3:0];
			key_pool.push_back(k);
		end
		key_pool.push_back(31'd0);
		key_pool.push_back(KEY_MAX);
	endtask

	// Random operations over pool keys, with a little noise, in phases of
	// changing insert and remove weight.
	task automatic test_random_mix();
		int ins_w [5] = '{50, 40, 25, 45, 35};
		int rem_w [5] = '{15, 25, 40, 20, 30};
		int phase;
		int i;
		int r;
		logic [lphm_pkg::KEY_W-1:0] k;
		for (phase = 0; phase < 5; phase++) begin
			idle_on = (phase != 2);
			build_pool();
			for (i = 0; i < 250; i++) begin
				r = $urandom_range(0, 99);
				k = key_pool[$urandom_range(0, key_pool.size() - 1)];
				if (r < 3)
					send_op(OP_UNUSED, lphm_pkg::KEY_W'($urandom), $urandom);
				else if (r < 5)
					send_op(lphm_pkg::OP_SEARCH, lphm_pkg::KEY_W'($urandom), $urandom);
				else if (r < 5 + ins_w[phase])
					send_op(lphm_pkg::OP_INSERT, k, $urandom);
				else if (r < 5 + ins_w[phase] + rem_w[phase])
					send_op(lphm_pkg::OP_REMOVE, k, $urandom);
				else
					send_op(lphm_pkg::OP_SEARCH, k, $urandom);
			end
			// Let the block run dry before the next phase.
			stop_sending();
			wait_drained();
		end
		idle_on = 1'b1;
	endtask

	// Receiver: random backpressure, none while idling is off.
	always @(negedge clk) begin
		if (!idle_on) begin
			m_tready <= 1'b1;
			ready_hold = 0;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if (m_tready) begin
			ready_hold = gap_len();
			if (ready_hold > 0) begin
				m_tready <= 1'b0;
				ready_hold--;
			end else begin
				ready_hold = $urandom_range(0, 4);
			end
		end else begin
			m_tready <= 1'b1;
			ready_hold = $urandom_range(0, 4);
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing pending: status %0d value %h",
					$time, m_tuser, m_tdata);
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				results_checked++;
				if (m_tuser !== exp_res.status) begin
					$display("%0t: status mismatch: expected %0d, got %0d",
						$time, exp_res.status, m_tuser);
					errors++;
				end
				if (m_tdata !== exp_res.found_value) begin
					$display("%0t: found_value mismatch: expected %h, got %h",
						$time, exp_res.found_value, m_tdata);
					errors++;
				end
			end
		end
	end

	// Watchdog: cycles with work outstanding but no beat moving.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (s_tvalid || pending_results.size() > 0) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending_results.size());
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		foreach (table_live[s]) begin
			table_key[s] = '0;
			table_value[s] = '0;
			table_live[s] = 1'b0;
			table_ever[s] = 1'b0;
		end
		errors = 0;
		ops_sent = 0;
		results_checked = 0;
		hits_seen = 0;
		full_seen = 0;
		quiet_cycles = 0;
		ready_hold = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_table_full();
		directed_ops = ops_sent;
		test_random_mix();

		stop_sending();
		wait_drained();
		repeat (SLOTS + 8) @(posedge clk);

		if (pending_results.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end
		$display("tb: %0d operations (%0d directed), %0d results checked", ops_sent,
			directed_ops, results_checked);
		$display("tb: %0d search hits, %0d table-full answers, %0d mismatches", hits_seen,
			full_seen, errors);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
